FILE: design/lif_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lif_pkg
// Shared types, codes and constants of the LIF neuron state engine.
// ----------------------------------------------------------------------------
package lif_pkg;

	localparam int NEURONS_DEF = 1024;

	localparam int CMD_W   = 2;
	localparam int IDX_W   = 10;
	localparam int DATA_W  = 32;
	localparam int CNT_W   = 8;
	localparam int REFR_W  = 8;
	localparam int SLOT_W  = 10;
	localparam int SHIFT_W = 30;
	localparam int SH_W    = 5;
	localparam int CFG_W   = 64;
	localparam int CFG_IDX_W = 3;

	// command codes
	localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SETTYPE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLRCNT  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THR_INHIB  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THR_EXCIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REFR_INHIB = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REFR_EXCIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SH_INHIB   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SH_EXCIT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR_INHIB = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR_EXCIT = 3'd7;

	// bit positions of the packed shift amounts
	localparam int SH_WEIGHT = 25;
	localparam int SH_V      = 20;
	localparam int SH_I      = 15;
	localparam int SH_RNDV   = 10;
	localparam int SH_RNDI   = 5;
	localparam int SH_VI     = 0;

	typedef struct packed {
		logic              typ;
		logic [REFR_W-1:0] refr;
		logic [CNT_W-1:0]  count;
		logic [DATA_W-1:0] volt;
		logic [DATA_W-1:0] curr;
	} entry_t;

	typedef struct packed {
		logic clr_en;
		logic capture;
		logic rd_en;
		logic calc_en;
		logic wr_en;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
	} dp_stat_t;

endpackage : lif_pkg
`default_nettype wire

FILE: design/lif_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lif_in_if
// Request channel: command, neuron index, delta, type bit and spike slot.
// ----------------------------------------------------------------------------
interface lif_in_if;
	logic                        valid;
	logic                        ready;
	logic [lif_pkg::CMD_W-1:0]   cmd;
	logic [lif_pkg::IDX_W-1:0]   neuron;
	logic signed [lif_pkg::DATA_W-1:0] delta;
	logic                        is_excitatory;
	logic [lif_pkg::SLOT_W-1:0]  spike_slot;

	modport source (output valid, cmd, neuron, delta, is_excitatory, spike_slot,
		input ready);
	modport sink (input valid, cmd, neuron, delta, is_excitatory, spike_slot,
		output ready);
endinterface : lif_in_if
`default_nettype wire

FILE: design/lif_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lif_out_if
// Result channel: spike flag, neuron state after the request, slot echo.
// ----------------------------------------------------------------------------
interface lif_out_if;
	logic                        valid;
	logic                        ready;
	logic                        spike;
	logic signed [lif_pkg::DATA_W-1:0] current_out;
	logic signed [lif_pkg::DATA_W-1:0] voltage_out;
	logic [lif_pkg::CNT_W-1:0]   spike_count;
	logic [lif_pkg::SLOT_W-1:0]  slot_out;

	modport source (output valid, spike, current_out, voltage_out, spike_count,
		slot_out, input ready);
	modport sink (input valid, spike, current_out, voltage_out, spike_count,
		slot_out, output ready);
endinterface : lif_out_if
`default_nettype wire

FILE: design/lif_neuron_state_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lif_neuron_state_engine
// Per-neuron current, voltage, spike count, refractory counter and type,
// updated by leaky-integrate-and-fire, add-delta, set-type and clear requests.
// ----------------------------------------------------------------------------
//  port     | dir | handshake      | carries
//  command  | in  | valid / ready  | cmd, neuron, delta, is_excitatory, spike_slot
//  result   | out | valid / ready  | spike, current_out, voltage_out, spike_count, slot_out
//  cfg_*    | in  | cfg_we only    | register index and write data
//
//  A request passes in turn through accept, memory read, shift-and-add stage,
//  threshold compare and write-back; its result is loaded into the output
//  register at write-back, which waits while the output register is full.
//  The state memory read-modify-write sets this order; one request is in flight at a time.
//  After reset the state memory is swept to zero, one entry a cycle, from entry 0
//  to NEURONS-1; command.ready stays low until the sweep ends.
//  A stalled result stays in the output register; the next request is still
//  accepted and waits at write-back until the output register frees.
// ----------------------------------------------------------------------------
module lif_neuron_state_engine #(
	parameter int NEURONS = lif_pkg::NEURONS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lif_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lif_pkg::CFG_W-1:0]     cfg_data,
	lif_in_if.sink                             command,
	lif_out_if.source                          result
);
	import lif_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  stat;
	logic      in_ready;

	assign command.ready = in_ready;

	lif_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (command.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (ctl)
	);

	lif_dpath #(
		.NEURONS (NEURONS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.command   (command),
		.result    (result),
		.cmd       (ctl),
		.stat      (stat)
	);

endmodule : lif_neuron_state_engine
`default_nettype wire

FILE: design/lif_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lif_ctrl
// Controller: clearing sweep after reset, then read / calc / write per request.
// ----------------------------------------------------------------------------
module lif_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire lif_pkg::dp_stat_t  stat,
	output lif_pkg::ctrl_cmd_t      cmd
);
	import lif_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_CALC  = 3'd3;
	localparam logic [2:0] S_WRITE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_CALC;
			end
			S_CALC: begin
				cmd.calc_en = 1'b1;
				state_d     = S_WRITE;
			end
			S_WRITE: begin
				// hold until the output register can take the result
				if (stat.out_free) begin
					cmd.wr_en = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule : lif_ctrl
`default_nettype wire

FILE: design/lif_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lif_dpath
// Datapath: configuration registers, neuron state memory, LIF arithmetic
// and the output register.
// ----------------------------------------------------------------------------
module lif_dpath #(
	parameter int NEURONS = lif_pkg::NEURONS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [lif_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lif_pkg::CFG_W-1:0]       cfg_data,
	lif_in_if.sink                               command,
	lif_out_if.source                            result,
	input  wire lif_pkg::ctrl_cmd_t              cmd,
	output lif_pkg::dp_stat_t                    stat
);
	import lif_pkg::*;

	localparam int ADDR_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;
	localparam int EXT_W  = 17;

	// configuration
	logic [DATA_W-1:0]  thr_q   [2];
	logic [REFR_W-1:0]  refr_q  [2];
	logic [SHIFT_W-1:0] shifts_q[2];
	logic [CFG_W-1:0]   pair_q  [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 2; k++) begin
				thr_q[k]    <= '0;
				refr_q[k]   <= '0;
				shifts_q[k] <= '0;
				pair_q[k]   <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THR_INHIB:  thr_q[0]    <= cfg_data[DATA_W-1:0];
				REG_THR_EXCIT:  thr_q[1]    <= cfg_data[DATA_W-1:0];
				REG_REFR_INHIB: refr_q[0]   <= cfg_data[REFR_W-1:0];
				REG_REFR_EXCIT: refr_q[1]   <= cfg_data[REFR_W-1:0];
				REG_SH_INHIB:   shifts_q[0] <= cfg_data[SHIFT_W-1:0];
				REG_SH_EXCIT:   shifts_q[1] <= cfg_data[SHIFT_W-1:0];
				REG_PAIR_INHIB: pair_q[0]   <= cfg_data;
				REG_PAIR_EXCIT: pair_q[1]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// request capture
	logic [CMD_W-1:0]  cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic              in_range_q;
	logic [DATA_W-1:0] delta_q;
	logic              newtype_q;
	logic [SLOT_W-1:0] slot_q;
	logic [EXT_W-1:0]  neuron_ext;

	assign neuron_ext = EXT_W'(command.neuron);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q      <= command.cmd;
			addr_q     <= neuron_ext[ADDR_W-1:0];
			in_range_q <= (neuron_ext < EXT_W'(NEURONS));
			delta_q    <= command.delta;
			newtype_q  <= command.is_excitatory;
			slot_q     <= command.spike_slot;
		end
	end

	// clearing sweep address
	logic [ADDR_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	assign stat.clr_last = (clr_addr_q == ADDR_W'(NEURONS - 1));

	// neuron state memory
	entry_t            mem [NEURONS];
	entry_t            rd_s1;
	entry_t            wr_entry;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	entry_t            mem_wd;

	assign mem_we = cmd.clr_en || (cmd.wr_en && in_range_q);
	assign mem_wa = cmd.clr_en ? clr_addr_q : addr_q;
	assign mem_wd = cmd.clr_en ? entry_t'('0) : wr_entry;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_s1 <= mem[addr_q];
		end
	end

	// leak, integrate and add delta
	logic [SHIFT_W-1:0] sh;
	logic [SH_W-1:0]    sh_w, sh_v, sh_i, sh_rv, sh_ri, sh_vi;
	logic signed [DATA_W-1:0] cur_s, volt_s;
	logic signed [DATA_W-1:0] rnd_i, rnd_v;
	logic [DATA_W-1:0]  i_dec_q, v_int_q, i_add_q;

	assign sh    = shifts_q[rd_s1.typ];
	assign sh_w  = sh[SH_WEIGHT +: SH_W];
	assign sh_v  = sh[SH_V      +: SH_W];
	assign sh_i  = sh[SH_I      +: SH_W];
	assign sh_rv = sh[SH_RNDV   +: SH_W];
	assign sh_ri = sh[SH_RNDI   +: SH_W];
	assign sh_vi = sh[SH_VI     +: SH_W];

	assign cur_s  = rd_s1.curr;
	assign volt_s = rd_s1.volt;
	assign rnd_i  = cur_s >>> sh_i;
	assign rnd_v  = volt_s >>> sh_v;

	always_ff @(posedge clk) begin
		if (cmd.calc_en) begin
			i_dec_q <= rd_s1.curr - DATA_W'(rnd_i >>> sh_ri);
			v_int_q <= rd_s1.volt - DATA_W'(rnd_v >>> sh_rv) + DATA_W'(cur_s >>> sh_vi);
			i_add_q <= rd_s1.curr + (delta_q << sh_w);
		end
	end

	// fire, reload and write back; also refractory countdown, add, set type and clear count
	logic fire;

	always_comb begin
		wr_entry = rd_s1;
		fire     = 1'b0;
		case (cmd_q)
			CMD_UPDATE: begin
				wr_entry.curr = i_dec_q;
				if (rd_s1.refr == '0) begin
					wr_entry.volt = v_int_q;
					if ($signed(v_int_q) > $signed(thr_q[rd_s1.typ])) begin
						fire           = 1'b1;
						wr_entry.volt  = pair_q[rd_s1.typ][CFG_W-1:DATA_W];
						wr_entry.curr  = pair_q[rd_s1.typ][DATA_W-1:0];
						wr_entry.refr  = refr_q[rd_s1.typ];
						wr_entry.count = rd_s1.count + CNT_W'(1);
					end
				end else begin
					wr_entry.refr = rd_s1.refr - REFR_W'(1);
				end
			end
			CMD_ADD: begin
				wr_entry.curr = i_add_q;
			end
			CMD_SETTYPE: begin
				wr_entry.typ = newtype_q;
			end
			CMD_CLRCNT: begin
				wr_entry.count = '0;
			end
			default: ;
		endcase
	end

	// output register
	logic              out_valid_q;
	logic              spike_q;
	logic [DATA_W-1:0] cur_out_q;
	logic [DATA_W-1:0] volt_out_q;
	logic [CNT_W-1:0]  cnt_out_q;
	logic [SLOT_W-1:0] slot_out_q;

	assign stat.out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.wr_en) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			spike_q    <= fire && in_range_q;
			cur_out_q  <= in_range_q ? wr_entry.curr  : '0;
			volt_out_q <= in_range_q ? wr_entry.volt  : '0;
			cnt_out_q  <= in_range_q ? wr_entry.count : '0;
			slot_out_q <= slot_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.spike       = spike_q;
	assign result.current_out = cur_out_q;
	assign result.voltage_out = volt_out_q;
	assign result.spike_count = cnt_out_q;
	assign result.slot_out    = slot_out_q;

endmodule : lif_dpath
`default_nettype wire
